// ===== hw/rtl/msmul_pkg.sv =====
// Shared constants, register indexes and the control state type of the
// multiword schoolbook multiplier. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msmul_pkg;

  // Limb width and the default limb capacity of either operand.
  localparam int LIMB_W        = 32;
  localparam int MAX_LIMBS_DEF = 32;

  // Configuration port shape.
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B_LENGTH = 2'd1;

  // Control states: take limbs, add one row, send the product.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multiword_schoolbook_multiplier.sv =====
// Multiword schoolbook multiplier: operand store, product store, row
// multiply-accumulate pipeline and result sender. Depends on msmul_pkg.
//
// Usage: set a_length (register 0) and b_length (register 1) through the
// cfg port while the block is idle; each write restarts the run. Then send
// a_length limbs of a followed by b_length limbs of b on the s_axis channel,
// least significant first. After the last b limb the block sends the
// a_length + b_length product limbs on m_axis, least significant first, with
// tlast on the final one. With b_length zero it sends a_length zero limbs
// right after the last a limb. Lengths of zero for a read as one; lengths
// above MAX_LIMBS read as MAX_LIMBS.
// Timing: a limbs are stored as they are taken, with no pause between them.
// A b limb starts a row: the row walks the a limbs through the operand and
// product memories at one limb per cycle, then a 32x32 multiply stage and a
// 64-bit accumulate stage, then writes the row's top carry limb. The product
// store has one read and one write port, which sets that walk. Results leave
// one per cycle while the receiver takes them; s_axis_tready is low during
// each row and from the last b limb until the final result transaction.
// Reset (rst, synchronous) sets both lengths to one and restarts the run;
// the memories are not cleared. When m_axis_tready is low the current
// result holds and the sender stops reading the product store.
`timescale 1ns / 1ps
`default_nettype none

module multiword_schoolbook_multiplier #(
  parameter int MAX_LIMBS = msmul_pkg::MAX_LIMBS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input limbs; tdata = limb_value[31:0]
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [msmul_pkg::LIMB_W-1:0]        s_axis_tdata,
  // Product limbs; tdata = product_limb[31:0], tlast = last_limb
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [msmul_pkg::LIMB_W-1:0]        m_axis_tdata,
  output logic                                m_axis_tlast,
  // Configuration writes
  input  wire                                 cfg_we,
  input  wire  [msmul_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [msmul_pkg::CFG_W-1:0]         cfg_data
);

  localparam int LW   = msmul_pkg::LIMB_W;
  localparam int AW   = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int PD   = 2 * MAX_LIMBS;
  localparam int PW   = $clog2(PD);
  localparam int CW   = $clog2(MAX_LIMBS + 1);
  localparam int NW   = $clog2(PD + 1);

  // Registers and memories.
  msmul_pkg::state_t            state, state_next;
  logic [msmul_pkg::CFG_W-1:0]  a_length, b_length;
  logic [LW-1:0]                a_mem [MAX_LIMBS];
  logic [LW-1:0]                p_mem [PD];
  logic [LW-1:0]                a_rdata, p_rdata;
  logic [NW-1:0]                load_count;
  logic [NW-1:0]                row;
  logic [LW-1:0]                limb;
  logic                         last_row;
  logic [CW-1:0]                rd_idx, wr_idx;
  logic                         s1_v, s2_v;
  logic [2*LW-1:0]              mul_reg;
  logic [LW-1:0]                addend;
  logic [LW-1:0]                carry;
  logic [NW-1:0]                emit_idx;
  logic                         out_valid, out_last, out_zero;

  // Combinational control.
  logic [CW-1:0]                an, bn;
  logic [NW-1:0]                total;
  logic                         cfg_hit, in_acc, is_a, a_ends_run;
  logic                         issue_rd, row_done, emit_issue, emit_done;
  logic [2*LW-1:0]              acc;
  logic                         p_we;
  logic [NW-1:0]                p_waddr_full, p_raddr_full;
  logic [LW-1:0]                p_wdata;

  // Effective lengths after the zero and saturation rules.
  always_comb begin
    if (a_length == '0) begin
      an = CW'(1);
    end else if (a_length > msmul_pkg::CFG_W'(MAX_LIMBS)) begin
      an = CW'(MAX_LIMBS);
    end else begin
      an = CW'(a_length);
    end
    if (b_length > msmul_pkg::CFG_W'(MAX_LIMBS)) begin
      bn = CW'(MAX_LIMBS);
    end else begin
      bn = CW'(b_length);
    end
    total = NW'(an) + NW'(bn);
  end

  assign cfg_hit = cfg_we && ((cfg_index == msmul_pkg::REG_A_LENGTH) ||
                              (cfg_index == msmul_pkg::REG_B_LENGTH));

  // Handshake and sequencing conditions.
  always_comb begin
    in_acc     = s_axis_tvalid && (state == msmul_pkg::ST_LOAD);
    is_a       = load_count < NW'(an);
    a_ends_run = is_a && ((load_count + NW'(1)) == NW'(an)) && (bn == '0);
    issue_rd   = (state == msmul_pkg::ST_ROW) && (rd_idx < an);
    row_done   = (state == msmul_pkg::ST_ROW) && (rd_idx == an) && !s1_v && !s2_v;
    emit_issue = (state == msmul_pkg::ST_EMIT) && (emit_idx < total) &&
                 (!out_valid || m_axis_tready);
    emit_done  = (state == msmul_pkg::ST_EMIT) && out_valid && m_axis_tready && out_last;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      msmul_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!is_a) begin
            state_next = msmul_pkg::ST_ROW;
          end else if (a_ends_run) begin
            state_next = msmul_pkg::ST_EMIT;
          end
        end
      end
      msmul_pkg::ST_ROW: begin
        if (row_done) begin
          state_next = last_row ? msmul_pkg::ST_EMIT : msmul_pkg::ST_LOAD;
        end
      end
      msmul_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_next = msmul_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = msmul_pkg::ST_LOAD;
      end
    endcase
  end

  // State register; a length write restarts the run.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state <= msmul_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Accumulate stage: product plus old row entry plus running carry.
  assign acc = mul_reg + {{LW{1'b0}}, addend} + {{LW{1'b0}}, carry};

  // Product store ports: row writes and the top carry share one write port.
  always_comb begin
    p_we         = ((state == msmul_pkg::ST_ROW) && s2_v) || row_done;
    p_waddr_full = s2_v ? (row + NW'(wr_idx)) : (row + NW'(an));
    p_wdata      = s2_v ? acc[LW-1:0] : carry;
    p_raddr_full = (state == msmul_pkg::ST_ROW) ? (row + NW'(rd_idx)) : emit_idx;
  end

  // Operand memory: written while loading a, read during each row.
  always_ff @(posedge clk) begin
    if (in_acc && is_a) begin
      a_mem[load_count[AW-1:0]] <= s_axis_tdata;
    end
    if (issue_rd) begin
      a_rdata <= a_mem[rd_idx[AW-1:0]];
    end
  end

  // Product memory: read-modify-write during rows, read out when sending.
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_waddr_full[PW-1:0]] <= p_wdata;
    end
    if (issue_rd || (emit_issue && !out_zero)) begin
      p_rdata <= p_mem[p_raddr_full[PW-1:0]];
    end
  end

  // Multiply stage; row zero starts from an empty product.
  always_ff @(posedge clk) begin
    if (s1_v) begin
      mul_reg <= {{LW{1'b0}}, a_rdata} * {{LW{1'b0}}, limb};
      addend  <= (row == '0) ? '0 : p_rdata;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_length <= msmul_pkg::CFG_W'(1);
      b_length <= msmul_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        msmul_pkg::REG_A_LENGTH: a_length <= cfg_data;
        msmul_pkg::REG_B_LENGTH: b_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Run counters, row pipeline control and the result register.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_count <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      out_valid  <= 1'b0;
      out_last   <= 1'b0;
      out_zero   <= 1'b0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      emit_idx   <= '0;
      row        <= '0;
      last_row   <= 1'b0;
      carry      <= '0;
      limb       <= '0;
    end else begin
      case (state)
        msmul_pkg::ST_LOAD: begin
          if (in_acc) begin
            emit_idx <= '0;
            if (is_a) begin
              out_zero   <= 1'b1;
              load_count <= a_ends_run ? '0 : (load_count + NW'(1));
            end else begin
              out_zero   <= 1'b0;
              row        <= load_count - NW'(an);
              limb       <= s_axis_tdata;
              last_row   <= (load_count + NW'(1) - NW'(an)) >= NW'(bn);
              load_count <= load_count + NW'(1);
              rd_idx     <= '0;
              wr_idx     <= '0;
              carry      <= '0;
            end
          end
        end
        msmul_pkg::ST_ROW: begin
          s1_v <= issue_rd;
          s2_v <= s1_v;
          if (issue_rd) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (s2_v) begin
            carry  <= acc[2*LW-1:LW];
            wr_idx <= wr_idx + CW'(1);
          end
          if (row_done && last_row) begin
            load_count <= '0;
          end
        end
        msmul_pkg::ST_EMIT: begin
          if (emit_issue) begin
            out_valid <= 1'b1;
            out_last  <= (emit_idx + NW'(1)) == total;
            emit_idx  <= emit_idx + NW'(1);
          end else if (m_axis_tready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Ports.
  assign s_axis_tready = (state == msmul_pkg::ST_LOAD);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_zero ? '0 : p_rdata;
  assign m_axis_tlast  = out_last;

  // Results are only shown while sending.
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == msmul_pkg::ST_EMIT))
    else $error("result valid outside the send phase");

  // The accumulate stage never writes past the top a limb of a row.
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (wr_idx < an))
    else $error("row write index past operand length");

  // While taking limbs, the run count stays inside the run.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == msmul_pkg::ST_LOAD) |-> (load_count < total))
    else $error("load count outside the run");

  // The send phase ends only on the final result transaction.
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    ((state == msmul_pkg::ST_EMIT) && !cfg_hit && (state_next == msmul_pkg::ST_LOAD))
      |-> (m_axis_tvalid && m_axis_tready && m_axis_tlast))
    else $error("send phase left before the last limb");

  // A row's writes never run ahead of its reads.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    ((state == msmul_pkg::ST_ROW) && s2_v) |=> (wr_idx <= rd_idx))
    else $error("row write ran ahead of reads");

endmodule

`default_nettype wire

// ===== tb/tb_multiword_schoolbook_multiplier.sv =====
// Self-checking testbench for the multiword schoolbook multiplier: operand
// limbs go in on the input stream, product limbs are checked against an
// in-bench predictor. Depends on msmul_pkg and the multiplier RTL.
`timescale 1ns / 1ps

module tb_multiword_schoolbook_multiplier;

  localparam int MAX_LIMBS     = msmul_pkg::MAX_LIMBS_DEF;
  localparam int RANDOM_ITEMS  = 480;
  // The longest row sets this; leave margin before an idle write.
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 300;

  // Register indexes outside the register list; writes there do nothing.
  localparam logic [msmul_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [msmul_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [msmul_pkg::LIMB_W-1:0] limb;
    logic                         last;
  } product_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [msmul_pkg::LIMB_W-1:0]    s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [msmul_pkg::LIMB_W-1:0]    m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_we = 1'b0;
  logic [msmul_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [msmul_pkg::CFG_W-1:0]     cfg_data = '0;

  // Predictor state: register copies, operand and partial product stores.
  logic [msmul_pkg::CFG_W-1:0]  a_len_reg;
  logic [msmul_pkg::CFG_W-1:0]  b_len_reg;
  logic [msmul_pkg::LIMB_W-1:0] a_limbs [MAX_LIMBS];
  logic [msmul_pkg::LIMB_W-1:0] partial_product [2*MAX_LIMBS];
  int unsigned                  limbs_taken;

  product_beat_t product_q[$];
  int unsigned   mismatches = 0;
  int unsigned   random_items = 0;
  int unsigned   hold_request = 0;
  int unsigned   hold_left = 0;
  bit            steady = 1'b0;

  multiword_schoolbook_multiplier #(.MAX_LIMBS(MAX_LIMBS)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // limb_value[31:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // product_limb[31:0]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Effective lengths: zero a reads as one, anything above capacity saturates.
  function automatic int unsigned a_limbs_used();
    if (a_len_reg == 0) return 1;
    if (a_len_reg > MAX_LIMBS) return MAX_LIMBS;
    return 32'(a_len_reg);
  endfunction

  function automatic int unsigned b_limbs_used();
    if (b_len_reg > MAX_LIMBS) return MAX_LIMBS;
    return 32'(b_len_reg);
  endfunction

  // Mirror of a register write; any listed register restarts the run.
  task automatic apply_reg(input logic [msmul_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msmul_pkg::CFG_W-1:0] val);
    if (idx == msmul_pkg::REG_A_LENGTH) begin
      a_len_reg   = val;
      limbs_taken = 0;
    end else if (idx == msmul_pkg::REG_B_LENGTH) begin
      b_len_reg   = val;
      limbs_taken = 0;
    end
  endtask

  // Takes one accepted limb; queues the product limbs when a run completes.
  task automatic predict_product(input logic [msmul_pkg::LIMB_W-1:0] limb);
    int unsigned an;
    int unsigned bn;
    int unsigned row;
    int unsigned i;
    logic [63:0] acc;
    logic [63:0] carry;
    an = a_limbs_used();
    bn = b_limbs_used();
    if (limbs_taken < an) begin
      a_limbs[limbs_taken] = limb;
      limbs_taken++;
      // Empty b: the product is a_length zero limbs.
      if (limbs_taken == an && bn == 0) begin
        for (i = 0; i < an; i++) product_q.push_back('{limb: '0, last: (i + 1 == an)});
        limbs_taken = 0;
      end
      return;
    end
    // One row: a times this limb, accumulated at the limb's position.
    row   = limbs_taken - an;
    carry = '0;
    for (i = 0; i < an; i++) begin
      acc = 64'(a_limbs[i]) * 64'(limb) + carry;
      if (row != 0) acc += 64'(partial_product[row + i]);
      partial_product[row + i] = acc[31:0];
      carry = acc >> 32;
    end
    partial_product[row + an] = carry[31:0];
    limbs_taken++;
    if (limbs_taken - an >= bn) begin
      for (i = 0; i < an + bn; i++)
        product_q.push_back('{limb: partial_product[i], last: (i + 1 == an + bn)});
      limbs_taken = 0;
    end
  endtask

  // Compares one product transaction with the oldest expectation.
  task automatic check_beat(input logic [msmul_pkg::LIMB_W-1:0] limb, input logic last);
    product_beat_t exp_beat;
    if (product_q.size() == 0) begin
      $display("%0t: unexpected product limb %h last %b", $time, limb, last);
      mismatches++;
      return;
    end
    exp_beat = product_q.pop_front();
    if (limb !== exp_beat.limb) begin
      $display("%0t: product_limb expected %h actual %h", $time, exp_beat.limb, limb);
      mismatches++;
    end
    if (last !== exp_beat.last) begin
      $display("%0t: last_limb expected %b actual %b", $time, exp_beat.last, last);
      mismatches++;
    end
  endtask

  // Result side: check each transaction, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata, m_axis_tlast);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 17);
    end
  end

  // Offers one limb after a random gap and returns at its transaction.
  // Valid stays high so back-to-back limbs need no second assignment.
  task automatic send_limb(input logic [msmul_pkg::LIMB_W-1:0] limb);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 17) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= limb;
    do @(posedge clk); while (!s_axis_tready);
    predict_product(limb);
  endtask

  // Biased limb values so carries and extremes show up often.
  function automatic logic [msmul_pkg::LIMB_W-1:0] pick_limb();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_limbs(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_limb(pick_limb());
  endtask

  // Stops offering, waits for every expected limb, then for the block to go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [msmul_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msmul_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_lengths(input logic [msmul_pkg::CFG_W-1:0] a_len,
                             input logic [msmul_pkg::CFG_W-1:0] b_len);
    settle();
    write_reg(msmul_pkg::REG_A_LENGTH, a_len);
    write_reg(msmul_pkg::REG_B_LENGTH, b_len);
  endtask

  // Lengths out of reset are one and one.
  task automatic test_reset_lengths();
    send_limb('1);
    send_limb('1);
    send_limb('0);
    send_limb(32'h8000_0000);
  endtask

  // All-ones operands drive the longest carry chains.
  task automatic test_carry_chain();
    int unsigned i;
    set_lengths(6'd3, 6'd2);
    for (i = 0; i < 5; i++) send_limb('1);
  endtask

  // Empty b gives a_length zero limbs right after a.
  task automatic test_empty_b();
    settle();
    write_reg(msmul_pkg::REG_B_LENGTH, 6'd0);
    send_limb(32'h1234_5678);
    send_limb('1);
    send_limb(32'h0000_0001);
  endtask

  // A zero a_length behaves as one limb.
  task automatic test_zero_a_length();
    set_lengths(6'd0, 6'd1);
    send_limb('1);
    send_limb(32'h8000_0000);
  endtask

  // Writes past the register list leave the run in progress alone.
  task automatic test_spare_index();
    send_limb(32'hDEAD_BEEF);
    settle();
    write_reg(REG_SPARE_2, 6'd63);
    write_reg(REG_SPARE_3, 6'd0);
    send_limb(32'hCAFE_F00D);
  endtask

  // A register write in the middle of a run starts it over.
  task automatic test_restart();
    set_lengths(6'd2, 6'd2);
    send_limb('1);
    send_limb(32'h7FFF_FFFF);
    send_limb('1);
    settle();
    write_reg(msmul_pkg::REG_B_LENGTH, 6'd2);
    send_limb(32'h0000_0001);
    send_limb('1);
    send_limb('1);
    send_limb(32'h8000_0000);
  endtask

  // Receiver holds off while the sender keeps offering whole runs.
  task automatic test_backpressure();
    int unsigned i;
    set_lengths(6'd2, 6'd1);
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 6; i++) send_random_limbs(3);
    // Pause until everything has drained, then carry on.
    s_axis_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    send_random_limbs(3);
    random_items += 21;
  endtask

  function automatic logic [msmul_pkg::CFG_W-1:0] pick_a_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return msmul_pkg::CFG_W'($urandom_range(33, 63));
    if (r < 6) return msmul_pkg::CFG_W'($urandom_range(28, 32));
    if (r < 10) return '0;
    return msmul_pkg::CFG_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [msmul_pkg::CFG_W-1:0] pick_b_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return msmul_pkg::CFG_W'($urandom_range(33, 63));
    if (r < 6) return msmul_pkg::CFG_W'($urandom_range(28, 32));
    if (r < 16) return '0;
    return msmul_pkg::CFG_W'($urandom_range(1, 6));
  endfunction

  // Batches of whole runs with random lengths, some abandoned part way.
  task automatic test_random_runs();
    int unsigned batch;
    int unsigned runs;
    int unsigned run_limbs;
    int unsigned cut;
    int unsigned i;
    batch = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      steady = (batch % 10 == 4);
      if ($urandom_range(5) != 0) begin
        if ($urandom_range(1) == 0) begin
          write_reg(msmul_pkg::REG_A_LENGTH, pick_a_length());
          write_reg(msmul_pkg::REG_B_LENGTH, pick_b_length());
        end else begin
          write_reg(msmul_pkg::REG_B_LENGTH, pick_b_length());
          if ($urandom_range(2) != 0) write_reg(msmul_pkg::REG_A_LENGTH, pick_a_length());
        end
      end
      run_limbs = a_limbs_used() + b_limbs_used();
      runs = (run_limbs > 20) ? 1 : $urandom_range(1, 4);
      for (i = 0; i < runs; i++) begin
        if (run_limbs > 1 && $urandom_range(9) == 0) begin
          // Broken run: part of the limbs, then a write restarts it.
          cut = $urandom_range(1, run_limbs - 1);
          send_random_limbs(cut);
          random_items += cut;
          settle();
          write_reg(msmul_pkg::REG_A_LENGTH, a_len_reg);
        end else begin
          send_random_limbs(run_limbs);
          random_items += run_limbs;
        end
      end
      batch++;
    end
    steady = 1'b0;
  endtask

  initial begin
    a_len_reg   = 6'd1;
    b_len_reg   = 6'd1;
    limbs_taken = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_lengths();
    test_carry_chain();
    test_empty_b();
    test_zero_a_length();
    test_spare_index();
    test_restart();
    test_backpressure();
    test_random_runs();

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
